/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the conflict counter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset
`define DMCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check an implication whose consequent lands in the next cycle
`define DMCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dmcc_pkg.sv */
// ----------------------------------------------------------------------------
// dmcc_pkg
// Types and constants shared by the direct-mapped conflict counter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dmcc_pkg;

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned BLK_W   = 28;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned LCNT_W  = 11;
  localparam int unsigned STEP_W  = $clog2(BLK_W);
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Default line store depth
  localparam int unsigned MAX_LINES_DEF = 1024;

  // Register reset values
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = SHIFT_W'(4);
  localparam logic [LCNT_W-1:0]  LINE_COUNT_RST  = LCNT_W'(1024);

  // Block shift limits
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(4);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(6);

  // Register select (address bit 2)
  localparam logic REG_BLOCK_SHIFT = 1'b0;
  localparam logic REG_LINE_COUNT  = 1'b1;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_en;    // write an empty entry at the sweep pointer
    logic load;      // capture a new item and start the remainder
    logic div_step;  // one restoring remainder step
    logic rd_en;     // read the addressed line
    logic commit;    // update line, count and output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // sweep pointer at the last entry
    logic div_last;  // final remainder step
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/dmcc_ctrl.sv */
// ----------------------------------------------------------------------------
// dmcc_ctrl
// Controller: sequences the clearing sweep, the remainder steps, the line
// read and the update for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmcc_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  dmcc_pkg::dp_sts_t  sts,
  output dmcc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DIV    = 5'b00100,
    S_READ   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_tvalid) state_nxt = S_DIV;
      S_DIV:    if (sts.div_last) state_nxt = S_READ;
      S_READ:   state_nxt = S_UPDATE;
      S_UPDATE: if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command decode
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    cmd.clr_en   = (state_r == S_CLEAR);
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.div_step = (state_r == S_DIV);
    cmd.rd_en    = (state_r == S_READ);
    cmd.commit   = (state_r == S_UPDATE) && sts.out_free;
  end

  `DMCC_ASSERT_NEXT(a_accept_starts_div, clk, rst_n, in_tvalid && in_tready, state_r == S_DIV, "accepted item did not start the remainder")
  `DMCC_ASSERT(a_commit_needs_slot, clk, rst_n, !cmd.commit || sts.out_free, "commit while output register busy")
  `DMCC_ASSERT(a_update_after_read, clk, rst_n, !(state_r == S_UPDATE) || ($past(state_r) == S_READ) || ($past(state_r) == S_UPDATE), "update without a line read")

endmodule

`default_nettype wire

/* rtl/core/dmcc_dp.sv */
// ----------------------------------------------------------------------------
// dmcc_dp
// Datapath: block number extraction, bit-serial remainder, line store with
// valid flags, saturating conflict count and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmcc_dp #(
  parameter int unsigned MAX_LINES = dmcc_pkg::MAX_LINES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  dmcc_pkg::dp_cmd_t                   cmd,
  output dmcc_pkg::dp_sts_t                   sts,
  input  wire [dmcc_pkg::SHIFT_W-1:0]         eff_shift,
  input  wire [dmcc_pkg::LCNT_W-1:0]          eff_lines,
  input  wire                                 in_command,
  input  wire [dmcc_pkg::ADDR_W-1:0]          in_address,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic                                out_conflict,
  output logic [dmcc_pkg::COUNT_W-1:0]        out_conflict_total
);

  localparam int unsigned IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned ENT_W = dmcc_pkg::BLK_W + 1;

  logic                           cmd_r;
  logic [dmcc_pkg::BLK_W-1:0]     blk_r;
  logic [dmcc_pkg::BLK_W-1:0]     dvd_r;
  logic [dmcc_pkg::BLK_W-1:0]     blk_nxt;
  logic [dmcc_pkg::LCNT_W-1:0]    rem_r;
  logic [dmcc_pkg::LCNT_W:0]      rem_shl;
  logic [dmcc_pkg::LCNT_W:0]      rem_sub;
  logic [dmcc_pkg::LCNT_W-1:0]    rem_nxt;
  logic [dmcc_pkg::STEP_W-1:0]    step_r;
  logic [IDX_W-1:0]               clr_idx_r;
  logic [IDX_W-1:0]               line_idx;
  logic [ENT_W-1:0]               line_mem [MAX_LINES];
  logic [ENT_W-1:0]               rdata_r;
  logic                           conflict;
  logic [dmcc_pkg::COUNT_W-1:0]   count_r;
  logic [dmcc_pkg::COUNT_W-1:0]   count_nxt;
  logic                           out_valid_r;
  logic                           out_conflict_r;
  logic [dmcc_pkg::COUNT_W-1:0]   out_total_r;

  // Block number: address shifted by the effective block size, zero-filled at the top for shifts 5 and 6
  always_comb begin
    case (eff_shift)
      3'd5:    blk_nxt = {1'b0, in_address[dmcc_pkg::ADDR_W-1:5]};
      3'd6:    blk_nxt = {2'b00, in_address[dmcc_pkg::ADDR_W-1:6]};
      default: blk_nxt = in_address[dmcc_pkg::ADDR_W-1:4];
    endcase
  end

  // One restoring remainder step: shift in the next dividend bit
  always_comb begin
    rem_shl = {rem_r, dvd_r[dmcc_pkg::BLK_W-1]};
    rem_sub = rem_shl - {1'b0, eff_lines};
    if (rem_shl >= {1'b0, eff_lines}) begin
      rem_nxt = rem_sub[dmcc_pkg::LCNT_W-1:0];
    end else begin
      rem_nxt = rem_shl[dmcc_pkg::LCNT_W-1:0];
    end
  end

  // Capture the item and run the remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      blk_r  <= blk_nxt;
      dvd_r  <= blk_nxt;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[dmcc_pkg::BLK_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign line_idx = IDX_W'(rem_r);

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_en) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // Line store: valid flag on top of the block number
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      line_mem[clr_idx_r] <= '0;
    end else if (cmd.commit) begin
      line_mem[line_idx] <= {1'b1, blk_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= line_mem[line_idx];
    end
  end

  // Conflict check and saturating count
  always_comb begin
    conflict = (cmd_r == dmcc_pkg::CMD_READ) && rdata_r[ENT_W-1] &&
               (rdata_r[dmcc_pkg::BLK_W-1:0] != blk_r);
    count_nxt = count_r;
    if (conflict && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_conflict_r <= conflict;
      out_total_r    <= count_nxt;
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_conflict       = out_conflict_r;
  assign out_conflict_total = out_total_r;

  always_comb begin
    sts.clr_last = (clr_idx_r == IDX_W'(MAX_LINES - 1));
    sts.div_last = (step_r == dmcc_pkg::STEP_W'(dmcc_pkg::BLK_W - 1));
    sts.out_free = !out_valid_r || out_tready;
  end

  `DMCC_ASSERT(a_rem_in_range, clk, rst_n, !cmd.rd_en || (rem_r < eff_lines), "line index not below line count")
  `DMCC_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid_r, "committed item not presented")
  `DMCC_ASSERT(a_no_clear_on_commit, clk, rst_n, !(cmd.clr_en && (cmd.commit || cmd.load)), "item work during clearing sweep")

endmodule

`default_nettype wire

/* rtl/core/direct_mapped_conflict_counter.sv */
// Operation: an accepted item runs 28 remainder steps, one line read and one update;
//   the update waits while the output register is busy. The remainder unit takes one
//   bit per cycle; a new item is accepted only after the last result is registered.
// Reset: synchronous, active low; the line store is then swept empty entry by entry,
//   during which no item is accepted (configuration writes are taken).
// ----------------------------------------------------------------------------
// direct_mapped_conflict_counter
// Tag store of a direct-mapped cache that flags and counts conflict misses.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_conflict_counter #(
  parameter int unsigned MAX_LINES = dmcc_pkg::MAX_LINES_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Configuration port
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire [dmcc_pkg::APB_AW-1:0]       cfg_paddr,
  input  wire [dmcc_pkg::APB_DW-1:0]       cfg_pwdata,
  output logic [dmcc_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready,
  // Input items
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [31:0]                       in_tdata,   // [31:0] address
  input  wire                              in_tuser,   // [0] command
  // Result items
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [31:0]                      out_tdata,  // [31:0] conflict_total
  output logic                             out_tuser   // [0] conflict
);

  logic [dmcc_pkg::SHIFT_W-1:0] block_shift_r;
  logic [dmcc_pkg::LCNT_W-1:0]  line_count_r;
  logic [dmcc_pkg::SHIFT_W-1:0] eff_shift;
  logic [dmcc_pkg::LCNT_W-1:0]  eff_lines;
  logic                         cfg_wr;
  dmcc_pkg::dp_cmd_t            cmd;
  dmcc_pkg::dp_sts_t            sts;

  // Register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= dmcc_pkg::BLOCK_SHIFT_RST;
      line_count_r  <= dmcc_pkg::LINE_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        dmcc_pkg::REG_BLOCK_SHIFT: block_shift_r <= cfg_pwdata[dmcc_pkg::SHIFT_W-1:0];
        dmcc_pkg::REG_LINE_COUNT:  line_count_r  <= cfg_pwdata[dmcc_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_paddr[2])
      dmcc_pkg::REG_BLOCK_SHIFT: cfg_prdata = dmcc_pkg::APB_DW'(block_shift_r);
      dmcc_pkg::REG_LINE_COUNT:  cfg_prdata = dmcc_pkg::APB_DW'(line_count_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Clamp the configuration to its usable range
  always_comb begin
    if (block_shift_r < dmcc_pkg::SHIFT_MIN) begin
      eff_shift = dmcc_pkg::SHIFT_MIN;
    end else if (block_shift_r > dmcc_pkg::SHIFT_MAX) begin
      eff_shift = dmcc_pkg::SHIFT_MAX;
    end else begin
      eff_shift = block_shift_r;
    end

    if (line_count_r == '0) begin
      eff_lines = dmcc_pkg::LCNT_W'(1);
    end else if (32'(line_count_r) > 32'(MAX_LINES)) begin
      eff_lines = dmcc_pkg::LCNT_W'(MAX_LINES);
    end else begin
      eff_lines = line_count_r;
    end
  end

  dmcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmcc_dp #(
    .MAX_LINES (MAX_LINES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .eff_shift          (eff_shift),
    .eff_lines          (eff_lines),
    .in_command         (in_tuser),
    .in_address         (in_tdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_conflict       (out_tuser),
    .out_conflict_total (out_tdata)
  );

endmodule

`default_nettype wire

/* tb/dmcc_conflict_monitor.sv */
// ----------------------------------------------------------------------------
// dmcc_conflict_monitor
// Watches the configuration port and both item channels of the conflict
// counter, keeps its own copy of the tag store, predicts the conflict flag
// and running count of every access, and compares each result item and register read with them.
// ----------------------------------------------------------------------------
module dmcc_conflict_monitor #(
  parameter int unsigned MAX_LINES = dmcc_pkg::MAX_LINES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dmcc_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [dmcc_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic [dmcc_pkg::APB_DW-1:0] cfg_prdata,
  input  logic                        cfg_pready,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] address
  input  logic                        in_tuser,   // [0] command
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [31:0]                 out_tdata,  // [31:0] conflict_total
  input  logic                        out_tuser,  // [0] conflict
  output int unsigned                 mismatch_count,
  output int unsigned                 accesses_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  import dmcc_pkg::*;

  typedef struct packed {
    logic               conflict;
    logic [COUNT_W-1:0] total;
  } access_outcome_t;

  // Shadow registers and tag store
  logic [SHIFT_W-1:0] shift_reg;
  logic [LCNT_W-1:0]  lines_reg;
  logic [BLK_W-1:0]   held_block [MAX_LINES];
  logic               line_full  [MAX_LINES];
  logic [COUNT_W-1:0] conflicts_so_far;

  access_outcome_t outcome_q[$];
  int unsigned     errors;
  int unsigned     in_flight;

  assign mismatch_count     = errors;
  assign accesses_in_flight = in_flight;

  // Look up and install one access; return the flag and count it produces
  function automatic access_outcome_t tally_access(input logic cmd,
                                                   input logic [ADDR_W-1:0] addr);
    logic [SHIFT_W-1:0] sh;
    logic [LCNT_W-1:0]  lines;
    logic [BLK_W-1:0]   blk;
    logic [BLK_W-1:0]   idx;
    access_outcome_t    res;
    sh = (shift_reg < SHIFT_MIN) ? SHIFT_MIN :
         (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
    lines = (lines_reg == '0) ? LCNT_W'(1) :
            (lines_reg > LCNT_W'(MAX_LINES)) ? LCNT_W'(MAX_LINES) : lines_reg;
    blk = BLK_W'(addr >> sh);
    idx = blk % BLK_W'(lines);
    res.conflict = 1'b0;
    if (cmd == CMD_READ && line_full[idx] && held_block[idx] != blk) begin
      res.conflict = 1'b1;
      // hold the count once it reaches all ones
      if (conflicts_so_far != '1) conflicts_so_far = conflicts_so_far + 1'b1;
    end
    held_block[idx] = blk;
    line_full[idx]  = 1'b1;
    res.total       = conflicts_so_far;
    return res;
  endfunction

  always @(posedge clk) begin
    access_outcome_t want;
    logic [APB_DW-1:0] reg_val;
    if (!rst_n) begin
      shift_reg        = BLOCK_SHIFT_RST;
      lines_reg        = LINE_COUNT_RST;
      conflicts_so_far = '0;
      for (int i = 0; i < MAX_LINES; i++) begin
        line_full[i]  = 1'b0;
        held_block[i] = '0;
      end
      outcome_q.delete();
      in_flight = 0;
    end else begin
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_LINE_COUNT) lines_reg = cfg_pwdata[LCNT_W-1:0];
        else shift_reg = cfg_pwdata[SHIFT_W-1:0];
      end
      // Compare register reads with the shadow copy
      if (cfg_psel && cfg_penable && !cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_LINE_COUNT) begin
          reg_val = APB_DW'(lines_reg);
          if (cfg_prdata !== reg_val) begin
            $error("line_count: expected %0d, got %0d", reg_val, cfg_prdata);
            errors++;
          end
        end else begin
          reg_val = APB_DW'(shift_reg);
          if (cfg_prdata !== reg_val) begin
            $error("block_shift: expected %0d, got %0d", reg_val, cfg_prdata);
            errors++;
          end
        end
      end
      // Check each result item against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $error("result item with no access outstanding: conflict %0d total %0d",
                 out_tuser, out_tdata);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          in_flight--;
          if (out_tuser !== want.conflict) begin
            $error("conflict: expected %0d, got %0d", want.conflict, out_tuser);
            errors++;
          end
          if (out_tdata !== want.total) begin
            $error("conflict_total: expected %0d, got %0d", want.total, out_tdata);
            errors++;
          end
        end
      end
      // Predict each accepted access
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(tally_access(in_tuser, in_tdata));
        in_flight++;
      end
    end
  end

endmodule

/* tb/tb_direct_mapped_conflict_counter.sv */
// ----------------------------------------------------------------------------
// tb_direct_mapped_conflict_counter
// Drives trace accesses and register settings into the conflict counter with
// random idling on both channels; the monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_direct_mapped_conflict_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import dmcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [APB_AW-1:0] ADDR_SHIFT = {REG_BLOCK_SHIFT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_LINES = {REG_LINE_COUNT, 2'b00};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              out_tuser;

  int unsigned mismatch_count;
  int unsigned accesses_in_flight;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          gaps_on = 1'b1;

  direct_mapped_conflict_counter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  dmcc_conflict_monitor monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .in_tuser           (in_tuser),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser),
    .mismatch_count     (mismatch_count),
    .accesses_in_flight (accesses_in_flight)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Give up on a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("direct_mapped_conflict_counter regression: fail");
    $finish;
  end

  // Stall the result side in bursts, with quiet stretches in between
  initial begin
    int  stall;
    bit  stalls_on;
    stall = 0;
    stalls_on = 1'b1;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) stalls_on = !stalls_on;
      if (!calm && stalls_on && stall == 0 && $urandom_range(0, 5) == 0)
        stall = $urandom_range(1, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One configuration transfer: setup, then access until pready
  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [APB_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Drain every outstanding access, then set the cache geometry and read it back
  task automatic set_geometry(input logic [SHIFT_W-1:0] shift_val,
                              input logic [LCNT_W-1:0] lines_val);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (accesses_in_flight != 0);
    apb_xfer(1'b1, ADDR_SHIFT, APB_DW'(shift_val));
    apb_xfer(1'b1, ADDR_LINES, APB_DW'(lines_val));
    apb_xfer(1'b0, ADDR_SHIFT, '0);
    apb_xfer(1'b0, ADDR_LINES, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Offer one access and hold it until the block takes it
  task automatic send_access(input logic cmd, input logic [31:0] addr);
    int gap;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if ($urandom_range(0, 29) == 0) gaps_on = !gaps_on;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
  endtask

  // Random trace that keeps hitting a few lines with a few different blocks
  task automatic run_trace(input int n, input int unsigned sh, input int unsigned lines);
    int unsigned tag_cap;
    int unsigned hot_tag [4];
    int unsigned hot_idx [4];
    logic [31:0] blk;
    logic [31:0] addr;
    logic        cmd;
    tag_cap = (32'hFFFF_FFFF >> sh) / lines - 1;
    hot_tag[0] = 0;
    hot_tag[1] = 1;
    hot_tag[2] = $urandom_range(0, tag_cap);
    hot_tag[3] = $urandom_range(0, tag_cap);
    for (int i = 0; i < 4; i++) hot_idx[i] = $urandom_range(0, lines - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        blk  = hot_tag[$urandom_range(0, 3)] * lines + hot_idx[$urandom_range(0, 3)];
        addr = (blk << sh) | ($urandom & ((32'd1 << sh) - 1));
      end else begin
        addr = $urandom;
      end
      cmd = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_READ;
      send_access(cmd, addr);
    end
  endtask

  initial begin
    int unsigned last_sh;
    int unsigned last_lines;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty line, same block, conflicts, writes, address extremes
    set_geometry(SHIFT_W'(4), LCNT_W'(1024));
    send_access(CMD_READ,  32'h0000_0000);
    send_access(CMD_READ,  32'h0000_000F);
    send_access(CMD_READ,  32'h0000_4000);
    send_access(CMD_WRITE, 32'h0000_0000);
    send_access(CMD_READ,  32'h0000_4000);
    send_access(CMD_WRITE, 32'h0000_4000);
    send_access(CMD_READ,  32'h0000_4008);
    send_access(CMD_READ,  32'hFFFF_FFFF);
    send_access(CMD_READ,  32'hFFFF_FFF0);
    send_access(CMD_READ,  32'h0003_FFF0);
    send_access(CMD_WRITE, 32'hFFFF_FFFF);
    send_access(CMD_READ,  32'h0003_FFF0);
    send_access(CMD_READ,  32'h8000_0000);
    send_access(CMD_READ,  32'h7FFF_FFFF);
    send_access(CMD_READ,  32'hAAAA_AAAA);
    send_access(CMD_READ,  32'h5555_5555);
    send_access(CMD_WRITE, 32'h1234_5678);
    send_access(CMD_READ,  32'h1234_5678);

    // Out-of-range settings clamp; stored lines carry over between geometries
    set_geometry(SHIFT_W'(0), LCNT_W'(0));
    run_trace(120, 4, 1);
    set_geometry(SHIFT_W'(7), LCNT_W'(2047));
    run_trace(200, 6, 1024);
    set_geometry(SHIFT_W'(6), LCNT_W'(1));
    run_trace(100, 6, 1);
    set_geometry(SHIFT_W'(5), LCNT_W'(3));
    run_trace(200, 5, 3);
    set_geometry(SHIFT_W'(3), LCNT_W'(1025));
    run_trace(150, 4, 1024);
    set_geometry(SHIFT_W'(4), LCNT_W'(16));
    run_trace(200, 4, 16);
    set_geometry(SHIFT_W'(5), LCNT_W'(1024));
    run_trace(150, 5, 1024);

    // Final stretch at full rate with a random geometry
    calm = 1'b1;
    last_sh    = $urandom_range(4, 6);
    last_lines = $urandom_range(1, 1024);
    set_geometry(SHIFT_W'(last_sh), LCNT_W'(last_lines));
    run_trace(180, last_sh, last_lines);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (accesses_in_flight != 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && accesses_in_flight == 0) begin
      $display("direct_mapped_conflict_counter regression: pass");
    end else begin
      $display("direct_mapped_conflict_counter regression: fail");
    end
    $finish;
  end

endmodule
